FILE: src/rrlt_pkg.sv
// rrlt_pkg: shared types and constants of the request/response latency tracker
`default_nettype none

package rrlt_pkg;

    localparam int KIND_W    = 2;
    localparam int TIME_W    = 64;
    localparam int LEN_W     = 32;
    localparam int LIMIT_W   = 40;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;

    // stream word widths, rounded up to whole bytes
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 168;

    localparam logic [LIMIT_W-1:0] STALL_LIMIT_RESET_NS = 40'd500000000;

    // input event kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE_SERVER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_IN   = 2'd1,
        DIR_OUT  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        STATUS_ONGOING = 2'd0,
        STATUS_SWITCH  = 2'd1,
        STATUS_DROP    = 2'd2
    } status_t;

endpackage

`default_nettype wire

FILE: src/request_response_latency_tracker_unit.sv
// request_response_latency_tracker_unit: per-connection request/response latency tracker
//
// the slave stream carries one i/o event per word (read, write or close, with
// enter and exit timestamps, byte count and a report-block flag); the master
// stream returns exactly one result word per event: run status, a transaction
// done flag with its latency, the previous run's byte counts and the switch count
// an event goes from the input register through one level of compare, subtract
// and select logic into the result register, which drives m_tvalid; one event
// per cycle is sustained while m_tready is high, since the tracking registers
// are updated in the same cycle as the result register
// the 64-bit stall subtract/compare and latency subtract set the clock path
// when the receiver holds m_tready low the result word stays put, the input
// register still takes one more word, and s_tready then drops until the
// result is taken
// reset clears all tracking state and both stream stages; role_server returns
// to 1 (server) and stall_limit_ns to 500 ms
// configuration is written through cfg_we/cfg_addr/cfg_wdata while the stream
// is idle: index 0 role_server, index 1 stall_limit_ns
`default_nettype none

module request_response_latency_tracker_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    // enter_time, exit_time, byte_len, emit_blocked, zero pad
    input  wire logic [rrlt_pkg::S_TDATA_W-1:0]        s_tdata,
    // kind
    input  wire logic [rrlt_pkg::KIND_W-1:0]           s_tuser,

    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // txn_done, txn_latency_ns, prev_in_bytes, prev_out_bytes, switch_count, zero pad
    output      logic [rrlt_pkg::M_TDATA_W-1:0]        m_tdata,
    // status
    output      logic [1:0]                            m_tuser,

    input  wire logic                                  cfg_we,
    input  wire logic [rrlt_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [rrlt_pkg::LIMIT_W-1:0]          cfg_wdata
);

    localparam int TW = rrlt_pkg::TIME_W;
    localparam int LW = rrlt_pkg::LEN_W;
    localparam int CW = rrlt_pkg::COUNT_W;

    // configuration
    logic                              role_server_reg;
    logic [rrlt_pkg::LIMIT_W-1:0]      stall_limit_reg;

    // input stage
    logic                              in_valid_reg, in_valid_next;
    logic [rrlt_pkg::KIND_W-1:0]       in_kind_reg;
    logic [TW-1:0]                     in_enter_reg;
    logic [TW-1:0]                     in_exit_reg;
    logic [LW-1:0]                     in_len_reg;
    logic                              in_blocked_reg;

    // result stage
    logic                              out_valid_reg, out_valid_next;
    rrlt_pkg::status_t                 out_status_reg;
    logic                              out_done_reg;
    logic [TW-1:0]                     out_latency_reg;
    logic [LW-1:0]                     out_prev_in_reg;
    logic [LW-1:0]                     out_prev_out_reg;
    logic [CW-1:0]                     out_switches_reg;

    // tracking state
    rrlt_pkg::dir_t cur_dir_reg,        cur_dir_next;
    logic [TW-1:0]  cur_start_reg,      cur_start_next;
    logic [TW-1:0]  cur_end_reg,        cur_end_next;
    logic [TW-1:0]  cur_txn_start_reg,  cur_txn_start_next;
    rrlt_pkg::dir_t last_dir_reg,       last_dir_next;
    logic [TW-1:0]  last_start_reg,     last_start_next;
    logic [TW-1:0]  last_end_reg,       last_end_next;
    logic [TW-1:0]  last_txn_start_reg, last_txn_start_next;
    logic [TW-1:0]  held_start_reg,     held_start_next;
    logic [TW-1:0]  held_txn_start_reg, held_txn_start_next;
    logic [LW-1:0]  in_bytes_reg,       in_bytes_next;
    logic [LW-1:0]  out_bytes_reg,      out_bytes_next;
    logic [LW-1:0]  last_in_bytes_reg,  last_in_bytes_next;
    logic [LW-1:0]  last_out_bytes_reg, last_out_bytes_next;
    logic [CW-1:0]  switches_reg,       switches_next;

    logic                              in_accept;
    logic                              advance;
    rrlt_pkg::status_t                 status_next;
    logic                              done_next;
    logic [TW-1:0]                     latency_next;

    rrlt_pkg::dir_t                    req_dir;
    rrlt_pkg::dir_t                    ev_dir;
    logic [TW-1:0]                     gap;
    logic                              stalled;
    logic [LW:0]                       in_sum;
    logic [LW:0]                       out_sum;
    logic [LW-1:0]                     in_sat;
    logic [LW-1:0]                     out_sat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_switches_reg, out_prev_out_reg, out_prev_in_reg,
                       out_latency_reg, out_done_reg};

    assign req_dir = role_server_reg ? rrlt_pkg::DIR_IN : rrlt_pkg::DIR_OUT;
    assign ev_dir  = (in_kind_reg == rrlt_pkg::KIND_READ) ? rrlt_pkg::DIR_IN
                                                          : rrlt_pkg::DIR_OUT;

    // stall check wraps modulo 2^64 like the timestamps
    assign gap     = in_exit_reg - cur_end_reg;
    assign stalled = (ev_dir == req_dir) && (gap > {24'd0, stall_limit_reg});

    assign in_sum  = {1'b0, in_bytes_reg} + {1'b0, in_len_reg};
    assign out_sum = {1'b0, out_bytes_reg} + {1'b0, in_len_reg};
    assign in_sat  = in_sum[LW] ? {LW{1'b1}} : in_sum[LW-1:0];
    assign out_sat = out_sum[LW] ? {LW{1'b1}} : out_sum[LW-1:0];

    always_comb
    begin
        cur_dir_next        = cur_dir_reg;
        cur_start_next      = cur_start_reg;
        cur_end_next        = cur_end_reg;
        cur_txn_start_next  = cur_txn_start_reg;
        last_dir_next       = last_dir_reg;
        last_start_next     = last_start_reg;
        last_end_next       = last_end_reg;
        last_txn_start_next = last_txn_start_reg;
        held_start_next     = held_start_reg;
        held_txn_start_next = held_txn_start_reg;
        in_bytes_next       = in_bytes_reg;
        out_bytes_next      = out_bytes_reg;
        last_in_bytes_next  = last_in_bytes_reg;
        last_out_bytes_next = last_out_bytes_reg;
        switches_next       = switches_reg;
        status_next         = rrlt_pkg::STATUS_ONGOING;
        done_next           = 1'b0;
        latency_next        = '0;

        case (in_kind_reg) inside
            rrlt_pkg::KIND_READ, rrlt_pkg::KIND_WRITE:
            begin
                if (cur_dir_reg == ev_dir)
                begin
                    if (ev_dir == rrlt_pkg::DIR_IN)
                        in_bytes_next = in_sat;
                    else
                        out_bytes_next = out_sat;
                    if (stalled)
                    begin
                        // drop everything but the running byte sums
                        cur_dir_next        = rrlt_pkg::DIR_NONE;
                        cur_start_next      = '0;
                        cur_end_next        = '0;
                        cur_txn_start_next  = '0;
                        last_dir_next       = rrlt_pkg::DIR_NONE;
                        last_start_next     = '0;
                        last_end_next       = '0;
                        last_txn_start_next = '0;
                        held_start_next     = '0;
                        held_txn_start_next = '0;
                        last_in_bytes_next  = '0;
                        last_out_bytes_next = '0;
                        switches_next       = '0;
                        status_next         = rrlt_pkg::STATUS_DROP;
                    end
                    else
                    begin
                        cur_end_next = in_exit_reg;
                    end
                end
                else
                begin
                    if (cur_dir_reg != rrlt_pkg::DIR_NONE)
                    begin
                        last_dir_next       = cur_dir_reg;
                        last_start_next     = cur_start_reg;
                        last_end_next       = cur_end_reg;
                        last_txn_start_next = cur_txn_start_reg;
                        last_in_bytes_next  = in_bytes_reg;
                        last_out_bytes_next = out_bytes_reg;
                    end
                    if (ev_dir == rrlt_pkg::DIR_IN)
                        in_bytes_next = in_len_reg;
                    else
                        out_bytes_next = in_len_reg;
                    cur_start_next = in_enter_reg;
                    cur_end_next   = in_exit_reg;
                    // a zero-length call leaves the direction open
                    if (in_len_reg != '0)
                    begin
                        cur_dir_next       = ev_dir;
                        cur_txn_start_next = in_exit_reg;
                    end
                    else
                    begin
                        cur_dir_next = rrlt_pkg::DIR_NONE;
                    end
                    status_next = rrlt_pkg::STATUS_SWITCH;
                end
            end
            rrlt_pkg::KIND_CLOSE:
            begin
                last_dir_next       = cur_dir_reg;
                last_start_next     = cur_start_reg;
                last_end_next       = cur_end_reg;
                last_txn_start_next = cur_txn_start_reg;
                last_in_bytes_next  = in_bytes_reg;
                last_out_bytes_next = out_bytes_reg;
                cur_dir_next        = rrlt_pkg::DIR_NONE;
                status_next         = rrlt_pkg::STATUS_SWITCH;
            end
            default:
            begin
                status_next = rrlt_pkg::STATUS_ONGOING;
            end
        endcase

        if (status_next == rrlt_pkg::STATUS_SWITCH)
        begin
            switches_next = switches_reg + 1'b1;
            if (last_dir_next == req_dir)
            begin
                held_start_next     = last_start_next;
                held_txn_start_next = last_txn_start_next;
            end
            else if (!in_blocked_reg && last_dir_next != rrlt_pkg::DIR_NONE &&
                     held_start_reg != '0)
            begin
                latency_next    = last_end_next - held_txn_start_reg;
                done_next       = 1'b1;
                held_start_next = '0;
            end
            if (in_kind_reg == rrlt_pkg::KIND_CLOSE)
                last_dir_next = rrlt_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_server_reg <= 1'b1;
            stall_limit_reg <= rrlt_pkg::STALL_LIMIT_RESET_NS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rrlt_pkg::CFG_ROLE_SERVER: role_server_reg <= cfg_wdata[0];
                rrlt_pkg::CFG_STALL_LIMIT: stall_limit_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg    <= s_tuser;
            in_enter_reg   <= s_tdata[63:0];
            in_exit_reg    <= s_tdata[127:64];
            in_len_reg     <= s_tdata[159:128];
            in_blocked_reg <= s_tdata[160];
        end
        if (advance)
        begin
            out_status_reg   <= status_next;
            out_done_reg     <= done_next;
            out_latency_reg  <= latency_next;
            out_prev_in_reg  <= last_in_bytes_next;
            out_prev_out_reg <= last_out_bytes_next;
            out_switches_reg <= switches_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_dir_reg        <= rrlt_pkg::DIR_NONE;
            cur_start_reg      <= '0;
            cur_end_reg        <= '0;
            cur_txn_start_reg  <= '0;
            last_dir_reg       <= rrlt_pkg::DIR_NONE;
            last_start_reg     <= '0;
            last_end_reg       <= '0;
            last_txn_start_reg <= '0;
            held_start_reg     <= '0;
            held_txn_start_reg <= '0;
            in_bytes_reg       <= '0;
            out_bytes_reg      <= '0;
            last_in_bytes_reg  <= '0;
            last_out_bytes_reg <= '0;
            switches_reg       <= '0;
        end
        else if (advance)
        begin
            cur_dir_reg        <= cur_dir_next;
            cur_start_reg      <= cur_start_next;
            cur_end_reg        <= cur_end_next;
            cur_txn_start_reg  <= cur_txn_start_next;
            last_dir_reg       <= last_dir_next;
            last_start_reg     <= last_start_next;
            last_end_reg       <= last_end_next;
            last_txn_start_reg <= last_txn_start_next;
            held_start_reg     <= held_start_next;
            held_txn_start_reg <= held_txn_start_next;
            in_bytes_reg       <= in_bytes_next;
            out_bytes_reg      <= out_bytes_next;
            last_in_bytes_reg  <= last_in_bytes_next;
            last_out_bytes_reg <= last_out_bytes_next;
            switches_reg       <= switches_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a drop clears the previous-run counts and the switch count
    a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rrlt_pkg::STATUS_DROP) |->
        (out_switches_reg == '0 && out_prev_in_reg == '0 && out_prev_out_reg == '0))
        else $error("drop result carries stale counts");

    // a transaction is only reported on a direction switch
    a_done_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_done_reg) |-> (m_tuser == rrlt_pkg::STATUS_SWITCH))
        else $error("transaction reported without a switch");

    a_latency_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_done_reg) |-> (out_latency_reg == '0))
        else $error("latency set without a transaction");

    // every processed event lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word lost");

    a_switch_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == rrlt_pkg::STATUS_SWITCH) |=>
        (switches_reg == $past(switches_reg) + 1'b1))
        else $error("switch count did not step");
`endif

endmodule

`default_nettype wire
